// ----- rtl/acrp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acrp_pkg
// Shared types and constants for the piecewise quadratic 1/acos evaluator.
// ----------------------------------------------------------------------------
package acrp_pkg;

  localparam int SEGMENTS_DEF = 15;

  localparam logic [31:0] F32_ONE  = 32'h3F80_0000;
  localparam logic [31:0] F32_HALF = 32'h3F00_0000;
  localparam logic [31:0] F32_QNAN = 32'hFFC0_0000;
  localparam logic [31:0] F32_QBIT = 32'h0040_0000;

  typedef enum logic {
    OP_EVAL  = 1'b0,
    OP_WRITE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    SEL_CONST  = 2'd0,
    SEL_LINEAR = 2'd1,
    SEL_QUAD   = 2'd2
  } coeff_sel_t;

endpackage

// ----- rtl/acrp_fmul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acrp_fmul
// Two-stage IEEE single multiplier, round to nearest even, full subnormals.
// ----------------------------------------------------------------------------
module acrp_fmul (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] r
);

  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) n = 6'(47 - i);
    end
    return n;
  endfunction

  logic [7:0]  ea, eb;
  logic [23:0] ma, mb;
  logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
  logic        sign_c, spec_c;
  logic [31:0] spec_val_c;
  logic [9:0]  esum_c;
  logic [47:0] prod_c;

  logic        s1_sign, s1_spec;
  logic [31:0] s1_spec_val;
  logic [9:0]  s1_esum;
  logic [47:0] s1_prod;

  always_comb begin
    ea     = a[30:23];
    eb     = b[30:23];
    ma     = {|ea, a[22:0]};
    mb     = {|eb, b[22:0]};
    nan_a  = (ea == 8'hFF) && (a[22:0] != 23'd0);
    nan_b  = (eb == 8'hFF) && (b[22:0] != 23'd0);
    inf_a  = (ea == 8'hFF) && (a[22:0] == 23'd0);
    inf_b  = (eb == 8'hFF) && (b[22:0] == 23'd0);
    zero_a = (a[30:0] == 31'd0);
    zero_b = (b[30:0] == 31'd0);
    sign_c = a[31] ^ b[31];
    esum_c = {2'b00, (ea == 8'd0) ? 8'd1 : ea} + {2'b00, (eb == 8'd0) ? 8'd1 : eb};
    prod_c = ma * mb;
    spec_c = 1'b1;
    spec_val_c = 32'd0;
    if (nan_a) begin
      spec_val_c = a | acrp_pkg::F32_QBIT;
    end else if (nan_b) begin
      spec_val_c = b | acrp_pkg::F32_QBIT;
    end else if ((inf_a && zero_b) || (zero_a && inf_b)) begin
      spec_val_c = acrp_pkg::F32_QNAN;
    end else if (inf_a || inf_b) begin
      spec_val_c = {sign_c, 8'hFF, 23'd0};
    end else if (zero_a || zero_b) begin
      spec_val_c = {sign_c, 31'd0};
    end else begin
      spec_c = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sign     <= sign_c;
      s1_spec     <= spec_c;
      s1_spec_val <= spec_val_c;
      s1_esum     <= esum_c;
      s1_prod     <= prod_c;
    end
  end

  logic [5:0]         lz;
  logic [47:0]        pn;
  logic signed [11:0] be;
  logic [11:0]        shv;
  logic [6:0]         sh;
  logic [71:0]        wide, lost_mask;
  logic [23:0]        m;
  logic               g, st, up;
  logic [7:0]         field;
  logic [30:0]        mag;
  logic [31:0]        res_c;

  always_comb begin
    lz        = lzc48(s1_prod);
    pn        = s1_prod << lz;
    be        = $signed(12'(s1_esum)) - 12'sd126 - $signed(12'(lz));
    shv       = 12'(12'sd1 - be);
    sh        = 7'd0;
    wide      = '0;
    lost_mask = '0;
    m         = pn[47:24];
    g         = pn[23];
    st        = |pn[22:0];
    field     = be[7:0];
    if (be < 12'sd1) begin
      sh        = (shv > 12'd72) ? 7'd72 : shv[6:0];
      wide      = {pn, 24'd0} >> sh;
      lost_mask = (72'd1 << sh) - 72'd1;
      m         = wide[71:48];
      g         = wide[47];
      st        = (|wide[46:0]) | (|({pn, 24'd0} & lost_mask));
      field     = 8'd0;
    end
    up  = g & (st | m[0]);
    mag = {field, m[22:0]} + {30'd0, up};
    if (s1_spec) begin
      res_c = s1_spec_val;
    end else if (be >= 12'sd255) begin
      res_c = {s1_sign, 8'hFF, 23'd0};
    end else begin
      res_c = {s1_sign, mag};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r <= res_c;
    end
  end

endmodule

// ----- rtl/acrp_fadd.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acrp_fadd
// Two-stage IEEE single adder: align and add, then normalize and round.
// ----------------------------------------------------------------------------
module acrp_fadd (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] r
);

  function automatic logic [4:0] lzc27(input logic [26:0] v);
    logic [4:0] n;
    n = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (v[i]) n = 5'(26 - i);
    end
    return n;
  endfunction

  logic        nan_a, nan_b, inf_a, inf_b;
  logic        swap, eff_sub, spec_c;
  logic [31:0] big, sml, spec_val_c;
  logic [7:0]  e_big, e_sml, d;
  logic [4:0]  sh;
  logic [23:0] m_big, m_sml;
  logic [53:0] full;
  logic [26:0] big27, sml27;
  logic [27:0] sum_c;

  logic        s1_sign, s1_zsign, s1_spec;
  logic [31:0] s1_spec_val;
  logic [7:0]  s1_exp;
  logic [27:0] s1_sum;

  always_comb begin
    nan_a   = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    nan_b   = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    inf_a   = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    inf_b   = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    swap    = b[30:0] > a[30:0];
    big     = swap ? b : a;
    sml     = swap ? a : b;
    e_big   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    e_sml   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    m_big   = {|big[30:23], big[22:0]};
    m_sml   = {|sml[30:23], sml[22:0]};
    d       = e_big - e_sml;
    sh      = (d > 8'd27) ? 5'd27 : d[4:0];
    full    = {m_sml, 3'd0, 27'd0} >> sh;
    big27   = {m_big, 3'd0};
    sml27   = {full[53:28], full[27] | (|full[26:0])};
    eff_sub = big[31] ^ sml[31];
    sum_c   = eff_sub ? ({1'b0, big27} - {1'b0, sml27}) : ({1'b0, big27} + {1'b0, sml27});
    spec_c  = 1'b1;
    spec_val_c = 32'd0;
    if (nan_a) begin
      spec_val_c = a | acrp_pkg::F32_QBIT;
    end else if (nan_b) begin
      spec_val_c = b | acrp_pkg::F32_QBIT;
    end else if (inf_a && inf_b && (a[31] != b[31])) begin
      spec_val_c = acrp_pkg::F32_QNAN;
    end else if (inf_a) begin
      spec_val_c = a;
    end else if (inf_b) begin
      spec_val_c = b;
    end else begin
      spec_c = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sign     <= big[31];
      s1_zsign    <= a[31] & b[31];
      s1_spec     <= spec_c;
      s1_spec_val <= spec_val_c;
      s1_exp      <= e_big;
      s1_sum      <= sum_c;
    end
  end

  logic [4:0]  lz;
  logic [7:0]  s;
  logic [26:0] n;
  logic [8:0]  field;
  logic [23:0] m;
  logic        g, st, up;
  logic [30:0] mag;
  logic [31:0] res_c;

  always_comb begin
    lz = lzc27(s1_sum[26:0]);
    s  = 8'd0;
    if (s1_sum[27]) begin
      n     = {s1_sum[27:2], s1_sum[1] | s1_sum[0]};
      field = {1'b0, s1_exp} + 9'd1;
    end else begin
      s     = ({3'd0, lz} < (s1_exp - 8'd1)) ? {3'd0, lz} : (s1_exp - 8'd1);
      n     = s1_sum[26:0] << s;
      field = n[26] ? ({1'b0, s1_exp} - {1'b0, s}) : 9'd0;
    end
    m   = n[26:3];
    g   = n[2];
    st  = |n[1:0];
    up  = g & (st | m[0]);
    mag = {field[7:0], m[22:0]} + {30'd0, up};
    if (s1_spec) begin
      res_c = s1_spec_val;
    end else if (s1_sum == 28'd0) begin
      res_c = {s1_zsign, 31'd0};
    end else if (field >= 9'd255) begin
      res_c = {s1_sign, 8'hFF, 23'd0};
    end else begin
      res_c = {s1_sign, mag};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r <= res_c;
    end
  end

endmodule

// ----- rtl/acos_reciprocal_piecewise_quadratic.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acos_reciprocal_piecewise_quadratic
// Piecewise quadratic approximation of 1/acos(x) in IEEE single precision,
// with coefficient tables loaded through the input stream.
// ----------------------------------------------------------------------------
//  channel  dir  tuser    tdata (lowest bit up)
//  s_axis   in   opcode   x_value, table_index, coeff_select, coeff_value
//  m_axis   out  -        result_value, segment
//
//  One transaction per cycle while the output is not stalled.
//  The pipeline is eight chained two-stage float units plus the table
//  stage; coefficient writes take effect at the table stage, in stream order.
//  rst clears all valid bits; tables hold garbage until written.
//  A stalled output freezes the whole pipeline; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module acos_reciprocal_piecewise_quadratic #(
  parameter int SEGMENTS = acrp_pkg::SEGMENTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // x_value, table_index, coeff_select, coeff_value
  input  logic        s_tuser,   // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // result_value, segment
);

  localparam int SEG_W = $clog2(SEGMENTS);
  localparam int LAST  = 17;
  localparam logic [31:0] F32_SCALE = {1'b0, 8'(127 + SEGMENTS), 23'd0};

  logic en;

  logic                 vld  [0:LAST];
  acrp_pkg::opcode_t    opr  [0:LAST];
  logic [31:0]          xr   [0:LAST];
  logic [3:0]           tidx [0:LAST];
  logic [1:0]           tsel [0:LAST];
  logic [31:0]          tval [0:LAST];
  logic                 tz   [0:LAST];
  logic [SEG_W-1:0]     seg  [0:LAST];
  logic [31:0]          ca   [0:LAST];
  logic [31:0]          cb   [0:LAST];
  logic [31:0]          cc   [0:LAST];

  logic [31:0] mem_a [SEGMENTS];
  logic [31:0] mem_b [SEGMENTS];
  logic [31:0] mem_c [SEGMENTS];

  logic [31:0] f_sum, f_t, f_rest, f_prod, f_qx, f_inner, f_lx, f_res;
  logic [SEG_W-1:0] seg_c;
  logic [SEG_W-1:0] waddr;
  logic             wr_ok;

  assign m_tvalid = vld[LAST] && (opr[LAST] == acrp_pkg::OP_EVAL);
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tdata  = {4'd0, 4'(seg[LAST]), f_res};

  always_comb begin
    if (tz[8]) begin
      seg_c = '0;
    end else if (f_prod[31] || (f_prod[30:23] < 8'd127) ||
                 ((f_prod[30:23] == 8'hFF) && (f_prod[22:0] != 23'd0))) begin
      seg_c = SEG_W'(SEGMENTS - 1);
    end else if (int'(f_prod[30:23]) > 126 + SEGMENTS) begin
      seg_c = '0;
    end else begin
      seg_c = SEG_W'(SEGMENTS + 126 - int'(f_prod[30:23]));
    end
  end

  assign waddr = SEG_W'(tidx[8]);
  assign wr_ok = vld[8] && (opr[8] == acrp_pkg::OP_WRITE) && (32'(tidx[8]) < SEGMENTS);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= LAST; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= s_tvalid;
      for (int k = 1; k <= LAST; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      opr[0]  <= acrp_pkg::opcode_t'(s_tuser);
      xr[0]   <= s_tdata[31:0];
      tidx[0] <= s_tdata[35:32];
      tsel[0] <= s_tdata[37:36];
      tval[0] <= s_tdata[69:38];
      tz[0]   <= 1'b0;
      seg[0]  <= '0;
      ca[0]   <= '0;
      cb[0]   <= '0;
      cc[0]   <= '0;
      for (int k = 1; k <= LAST; k++) begin
        opr[k]  <= opr[k-1];
        xr[k]   <= xr[k-1];
        tidx[k] <= tidx[k-1];
        tsel[k] <= tsel[k-1];
        tval[k] <= tval[k-1];
        if (k != 5) begin
          tz[k] <= tz[k-1];
        end
        if (k != 9) begin
          seg[k] <= seg[k-1];
          ca[k]  <= ca[k-1];
          cb[k]  <= cb[k-1];
          cc[k]  <= cc[k-1];
        end
      end
      tz[5]  <= (f_t[30:0] == 31'd0);
      seg[9] <= seg_c;
      ca[9]  <= mem_a[seg_c];
      cb[9]  <= mem_b[seg_c];
      cc[9]  <= mem_c[seg_c];
      if (wr_ok) begin
        case (acrp_pkg::coeff_sel_t'(tsel[8]))
          acrp_pkg::SEL_CONST:  mem_a[waddr] <= tval[8];
          acrp_pkg::SEL_LINEAR: mem_b[waddr] <= tval[8];
          acrp_pkg::SEL_QUAD:   mem_c[waddr] <= tval[8];
          default: ;
        endcase
      end
    end
  end

  acrp_fadd u_add_sum (.clk(clk), .en(en), .a(xr[0]), .b(acrp_pkg::F32_ONE), .r(f_sum));
  acrp_fmul u_mul_t (.clk(clk), .en(en), .a(f_sum), .b(acrp_pkg::F32_HALF), .r(f_t));
  acrp_fadd u_add_rest (.clk(clk), .en(en), .a(acrp_pkg::F32_ONE),
                        .b({~f_t[31], f_t[30:0]}), .r(f_rest));
  acrp_fmul u_mul_prod (.clk(clk), .en(en), .a(f_rest), .b(F32_SCALE), .r(f_prod));
  acrp_fmul u_mul_qx (.clk(clk), .en(en), .a(xr[9]), .b(cc[9]), .r(f_qx));
  acrp_fadd u_add_in (.clk(clk), .en(en), .a(f_qx), .b(cb[11]), .r(f_inner));
  acrp_fmul u_mul_lx (.clk(clk), .en(en), .a(xr[13]), .b(f_inner), .r(f_lx));
  acrp_fadd u_add_res (.clk(clk), .en(en), .a(f_lx), .b(ca[15]), .r(f_res));

endmodule

// ----- tb/acos_reciprocal_piecewise_quadratic_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acos_reciprocal_piecewise_quadratic_tb
// Streams coefficient writes and evaluations into the 1/acos evaluator and
// checks every result against a bit-exact single precision predictor with
// random idling on both stream sides.
// ----------------------------------------------------------------------------
module acos_reciprocal_piecewise_quadratic_tb;

  localparam int          NSEG       = acrp_pkg::SEGMENTS_DEF;
  localparam int          CYCLE_CAP  = 300000;
  localparam int          DRAIN_WAIT = 40;
  localparam logic [31:0] F32_SEGSCL = 32'h4700_0000;
  localparam logic [31:0] F32_SEGLIM = 32'h4780_0000;

  typedef struct packed {
    acrp_pkg::opcode_t op;
    logic [31:0] x;
    logic [3:0]  idx;
    logic [1:0]  sel;
    logic [31:0] coeff;
    logic        drain;
  } item_t;

  typedef struct packed {
    logic [31:0] value;
    logic [3:0]  seg;
  } approx_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;

  item_t       pending_items[$];
  approx_t     expected_approx[$];
  logic [31:0] tbl_const[NSEG];
  logic [31:0] tbl_linear[NSEG];
  logic [31:0] tbl_quad[NSEG];
  item_t       cur_item;
  int          cycles = 0;
  int          errors = 0;
  int          n_eval = 0;
  int          n_write = 0;
  int          drain_cnt = 0;
  logic        stim_done = 1'b0;

  acos_reciprocal_piecewise_quadratic uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #1 clk = ~clk;

  function automatic logic f32_is_nan(input logic [31:0] a);
    return a[30:23] == 8'hFF && a[22:0] != 0;
  endfunction

  function automatic logic [31:0] f32_round(input logic s, input logic [299:0] sig,
                                            input int scale);
    int p, sh, bexp;
    logic [299:0] keep, mask;
    logic half, sticky;
    if (sig == 0) return {s, 31'b0};
    p = 0;
    for (int i = 0; i < 300; i++) if (sig[i]) p = i;
    bexp = p + scale + 127;
    if (bexp >= 1) sh = p - 23;
    else sh = -149 - scale;
    if (sh > 0) begin
      keep = sig >> sh;
      half = sig[sh-1];
      mask = (300'b1 << (sh - 1)) - 300'b1;
      sticky = |(sig & mask);
      if (half && (sticky || keep[0])) keep = keep + 1;
    end else begin
      keep = sig << (-sh);
    end
    if (bexp >= 1) begin
      if (keep[24]) begin
        keep = keep >> 1;
        bexp++;
      end
      if (bexp >= 255) return {s, 8'hFF, 23'b0};
      return {s, bexp[7:0], keep[22:0]};
    end
    return {s, keep[30:0]};
  endfunction

  function automatic logic [31:0] f32_mul(input logic [31:0] a, input logic [31:0] b);
    logic s;
    logic [23:0] ma, mb;
    int ea, eb;
    s = a[31] ^ b[31];
    if (f32_is_nan(a)) return a | acrp_pkg::F32_QBIT;
    if (f32_is_nan(b)) return b | acrp_pkg::F32_QBIT;
    if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) begin
      if (a[30:0] == 0 || b[30:0] == 0) return acrp_pkg::F32_QNAN;
      return {s, 8'hFF, 23'b0};
    end
    ma = {a[30:23] != 0, a[22:0]};
    mb = {b[30:23] != 0, b[22:0]};
    ea = (a[30:23] == 0) ? 1 : int'(a[30:23]);
    eb = (b[30:23] == 0) ? 1 : int'(b[30:23]);
    return f32_round(s, 300'(ma) * 300'(mb), ea + eb - 300);
  endfunction

  function automatic logic [31:0] f32_add(input logic [31:0] a, input logic [31:0] b);
    logic [299:0] aa, bb;
    int ea, eb, emin;
    if (f32_is_nan(a)) return a | acrp_pkg::F32_QBIT;
    if (f32_is_nan(b)) return b | acrp_pkg::F32_QBIT;
    if (a[30:23] == 8'hFF) begin
      if (b[30:23] == 8'hFF && a[31] != b[31]) return acrp_pkg::F32_QNAN;
      return a;
    end
    if (b[30:23] == 8'hFF) return b;
    if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'b0};
    ea = (a[30:23] == 0) ? 1 : int'(a[30:23]);
    eb = (b[30:23] == 0) ? 1 : int'(b[30:23]);
    emin = (ea < eb) ? ea : eb;
    aa = 300'({a[30:23] != 0, a[22:0]}) << (ea - emin);
    bb = 300'({b[30:23] != 0, b[22:0]}) << (eb - emin);
    if (a[31] == b[31]) return f32_round(a[31], aa + bb, emin - 150);
    if (aa > bb) return f32_round(a[31], aa - bb, emin - 150);
    if (bb > aa) return f32_round(b[31], bb - aa, emin - 150);
    return 32'h0;
  endfunction

  function automatic logic [3:0] segment_of(input logic [31:0] x);
    logic [31:0] t, prod, v;
    int len;
    t = f32_mul(f32_add(x, acrp_pkg::F32_ONE), acrp_pkg::F32_HALF);
    if (t[30:0] == 0) return 4'd0;
    prod = f32_mul(f32_add(acrp_pkg::F32_ONE, t ^ 32'h8000_0000), F32_SEGSCL);
    if (f32_is_nan(prod) || (prod[31] && prod[30:0] != 0)) v = 0;
    else if (!prod[31] && prod >= F32_SEGLIM) v = 32'hFFFF;
    else if (prod[30:23] < 8'd127) v = 0;
    else v = {8'b0, 1'b1, prod[22:0]} >> (150 - int'(prod[30:23]));
    if (v == 0) return 4'(NSEG - 1);
    len = 0;
    for (int i = 0; i < 32; i++) if (v[i]) len = i + 1;
    if (len > NSEG) return 4'd0;
    return 4'(NSEG - len);
  endfunction

  task automatic apply_item(input item_t it);
    approx_t r;
    logic [3:0] sg;
    if (it.op == acrp_pkg::OP_WRITE) begin
      n_write++;
      if (it.idx < NSEG) begin
        if (it.sel == acrp_pkg::SEL_CONST) tbl_const[it.idx] = it.coeff;
        else if (it.sel == acrp_pkg::SEL_LINEAR) tbl_linear[it.idx] = it.coeff;
        else if (it.sel == acrp_pkg::SEL_QUAD) tbl_quad[it.idx] = it.coeff;
      end
    end else begin
      n_eval++;
      sg = segment_of(it.x);
      r.seg = sg;
      r.value = f32_add(f32_mul(it.x, f32_add(f32_mul(it.x, tbl_quad[sg]), tbl_linear[sg])),
                        tbl_const[sg]);
      expected_approx.push_back(r);
    end
  endtask

  function automatic logic idle_now();
    if (cycles >= 150 && cycles < 450) return 1'b0;
    return $urandom_range(99) < 19;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    item_t nxt;
    logic  give;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) apply_item(cur_item);
      give = 1'b0;
      if (pending_items.size() > 0 && !idle_now()) begin
        if (pending_items[0].drain) begin
          if (expected_approx.size() != 0 || s_tvalid) drain_cnt = 0;
          else drain_cnt++;
          give = drain_cnt > DRAIN_WAIT;
        end else begin
          give = 1'b1;
        end
      end
      if (give) begin
        nxt = pending_items.pop_front();
        drain_cnt = 0;
        cur_item <= nxt;
        s_tuser  <= nxt.op;
        s_tdata  <= {2'b0, nxt.coeff, nxt.sel, nxt.idx, nxt.x};
      end
      s_tvalid <= give;
    end
  end

  always @(posedge clk) begin
    approx_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_approx.size() == 0) begin
        $error("unexpected result: result_value %h segment %0d", m_tdata[31:0],
               m_tdata[35:32]);
        errors++;
      end else begin
        want = expected_approx.pop_front();
        if (m_tdata[31:0] !== want.value) begin
          $error("result_value expected %h actual %h", want.value, m_tdata[31:0]);
          errors++;
        end
        if (m_tdata[35:32] !== want.seg) begin
          $error("segment expected %0d actual %0d", want.seg, m_tdata[35:32]);
          errors++;
        end
      end
    end
    m_tready <= rst ? 1'b0 : !idle_now();
  end

  function automatic logic [31:0] plain_coeff();
    return {1'($urandom_range(1)), 8'($urandom_range(132, 118)), 23'($urandom)};
  endfunction

  function automatic logic [31:0] random_x();
    int k;
    k = $urandom_range(99);
    if (k < 45) return {1'($urandom_range(1)), 8'($urandom_range(126)), 23'($urandom)};
    if (k < 65) return acrp_pkg::F32_ONE - $urandom_range(1 << 20, 1);
    if (k < 80) return 32'hBF80_0000 - $urandom_range(1 << 20, 1);
    if (k < 90) return {1'($urandom_range(1)), 8'($urandom_range(126, 100)), 23'($urandom)};
    return $urandom;
  endfunction

  task automatic add_eval(input logic [31:0] x, input logic drain = 1'b0);
    item_t it;
    it = '{op: acrp_pkg::OP_EVAL, x: x, idx: 4'($urandom), sel: 2'($urandom),
           coeff: $urandom, drain: drain};
    pending_items.push_back(it);
  endtask

  task automatic add_write(input logic [3:0] idx, input logic [1:0] sel,
                           input logic [31:0] c);
    item_t it;
    it = '{op: acrp_pkg::OP_WRITE, x: $urandom, idx: idx, sel: sel, coeff: c, drain: 1'b0};
    pending_items.push_back(it);
  endtask

  initial begin
    logic [31:0] corner_x[20];
    corner_x = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
                 32'h3F7F_FFFF, 32'hBF7F_FFFF, 32'h0000_0001, 32'h8000_0001,
                 32'h3F00_0000, 32'hBF00_0000, 32'h7FC0_0000, 32'h7F80_0001,
                 32'h7F80_0000, 32'hFF80_0000, 32'h3FC0_0000, 32'hC000_0000,
                 32'hFFFF_FFFF, 32'h7F7F_FFFF, 32'h3F7F_FF00, 32'h3F7F_0000};
    for (int i = 0; i < NSEG; i++) begin
      tbl_const[i] = '0;
      tbl_linear[i] = '0;
      tbl_quad[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < NSEG; i++) begin
      add_write(4'(i), acrp_pkg::SEL_CONST, plain_coeff());
      add_write(4'(i), acrp_pkg::SEL_LINEAR, plain_coeff());
      add_write(4'(i), acrp_pkg::SEL_QUAD, plain_coeff());
    end
    foreach (corner_x[i]) add_eval(corner_x[i]);
    add_write(4'd15, acrp_pkg::SEL_CONST, 32'hFFFF_FFFF);
    add_write(4'd3, 2'd3, 32'hFFFF_FFFF);
    add_eval(32'h3E80_0000);
    for (int n = 0; n < 650; n++) begin
      if ($urandom_range(99) < 15)
        add_write(4'($urandom_range(15)), 2'($urandom_range(3)),
                  ($urandom_range(99) < 20) ? $urandom : plain_coeff());
      else
        add_eval(random_x(), n == 325);
    end
    wait (pending_items.size() == 0 && !s_tvalid);
    wait (expected_approx.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Covered %0d evaluations and %0d table writes, corners and out-of-range",
             n_eval, n_write);
    $display("arguments included, with random stalls on input and output.");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
